// File: rtl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg: shared types and constants of the I2C master byte engine
// Command codes, bus sequencer phases, ACK status codes, configuration
// register indexes and the result record that travels to the output stage.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 8;
  localparam int unsigned BITS_PER_BYTE = 8;

  localparam logic [7:0] HALF_BIT_RST = 8'd2;
  localparam logic [7:0] ACK_WAIT_RST = 8'd100;

  typedef enum logic [2:0] {
    CMD_TICK  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4
  } cmd_t;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_S1    = 4'd1,
    PH_S2    = 4'd2,
    PH_P1    = 4'd3,
    PH_P2    = 4'd4,
    PH_WLOW  = 4'd5,
    PH_WHIGH = 4'd6,
    PH_AWAIT = 4'd7,
    PH_AHIGH = 4'd8,
    PH_RLOW  = 4'd9,
    PH_RHIGH = 4'd10,
    PH_KLOW  = 4'd11,
    PH_KHIGH = 4'd12
  } phase_t;

  typedef enum logic [1:0] {
    ST_ACKED   = 2'd0,
    ST_TIMEOUT = 2'd1,
    ST_LOST    = 2'd2
  } ack_status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HALF_BIT = 2'd0,
    CFG_ACK_WAIT = 2'd1
  } cfg_idx_t;

  typedef struct packed {
    logic       scl_release;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic [1:0] ack_status;
  } res_t;

endpackage

// File: rtl/i2cm_core.sv
// ----------------------------------------------------------------------------
// i2cm_core: bus sequencer of the I2C master byte engine
// Holds the configuration and the sequencer state; advances one tick per
// accepted transaction and presents the resulting line and status record.
// ----------------------------------------------------------------------------
module i2cm_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               step,
  input  logic [2:0]                         cmd,
  input  logic [7:0]                         tx_byte,
  input  logic                               give_ack,
  input  logic                               sda_in,
  input  logic                               cfg_we,
  input  logic [i2cm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [i2cm_pkg::CFG_DAT_W-1:0]     cfg_data,
  output i2cm_pkg::res_t                     res
);

  logic [7:0]       half_bit_r;
  logic [7:0]       ack_wait_r;
  i2cm_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]       bit_r, bit_nxt;
  logic [7:0]       shift_r, shift_nxt;
  logic [7:0]       tick_r, tick_nxt;
  logic [7:0]       wait_r, wait_nxt;
  logic             ack_wanted_r, ack_wanted_nxt;
  logic [1:0]       status_r, status_nxt;
  logic [7:0]       rx_hold_r, rx_hold_nxt;
  logic             scl_r, scl_nxt;
  logic             sda_r, sda_nxt;
  logic             done;
  logic [7:0]       seg_len;
  logic [3:0]       bit_inc;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_bit_r <= i2cm_pkg::HALF_BIT_RST;
      ack_wait_r <= i2cm_pkg::ACK_WAIT_RST;
    end else if (cfg_we) begin
      if (cfg_index == i2cm_pkg::CFG_HALF_BIT) begin
        half_bit_r <= cfg_data;
      end
      if (cfg_index == i2cm_pkg::CFG_ACK_WAIT) begin
        ack_wait_r <= cfg_data;
      end
    end
  end

  assign seg_len = (half_bit_r == 8'd0) ? 8'd1 : half_bit_r;
  assign bit_inc = bit_r + 4'd1;

  always_comb begin
    phase_nxt      = phase_r;
    bit_nxt        = bit_r;
    shift_nxt      = shift_r;
    tick_nxt       = tick_r;
    wait_nxt       = wait_r;
    ack_wanted_nxt = ack_wanted_r;
    status_nxt     = status_r;
    rx_hold_nxt    = rx_hold_r;
    scl_nxt        = scl_r;
    sda_nxt        = sda_r;
    done           = 1'b0;
    if (step) begin
      unique case (phase_r)
        i2cm_pkg::PH_IDLE: begin
          unique case (cmd)
            i2cm_pkg::CMD_START: begin
              scl_nxt   = 1'b1;
              sda_nxt   = 1'b1;
              phase_nxt = i2cm_pkg::PH_S1;
              tick_nxt  = seg_len;
            end
            i2cm_pkg::CMD_STOP: begin
              sda_nxt   = 1'b0;
              phase_nxt = i2cm_pkg::PH_P1;
              tick_nxt  = seg_len;
            end
            i2cm_pkg::CMD_WRITE: begin
              shift_nxt = tx_byte;
              bit_nxt   = 4'd0;
              scl_nxt   = 1'b0;
              sda_nxt   = tx_byte[7];
              phase_nxt = i2cm_pkg::PH_WLOW;
              tick_nxt  = seg_len;
            end
            i2cm_pkg::CMD_READ: begin
              shift_nxt      = 8'd0;
              bit_nxt        = 4'd0;
              ack_wanted_nxt = give_ack;
              scl_nxt        = 1'b0;
              sda_nxt        = 1'b1;
              phase_nxt      = i2cm_pkg::PH_RLOW;
              tick_nxt       = seg_len;
            end
            default: begin
              // tick only, or an unknown code: nothing to start
            end
          endcase
        end
        i2cm_pkg::PH_AWAIT: begin
          if (!sda_in) begin
            scl_nxt   = 1'b1;
            phase_nxt = i2cm_pkg::PH_AHIGH;
            tick_nxt  = seg_len;
          end else begin
            wait_nxt = wait_r - 8'd1;
            if (wait_r == 8'd1) begin
              status_nxt = i2cm_pkg::ST_TIMEOUT;
              scl_nxt    = 1'b0;
              done       = 1'b1;
            end
          end
        end
        default: begin
          tick_nxt = tick_r - 8'd1;
          if (tick_r == 8'd1) begin
            unique case (phase_r)
              i2cm_pkg::PH_S1: begin
                sda_nxt   = 1'b0;
                phase_nxt = i2cm_pkg::PH_S2;
                tick_nxt  = seg_len;
              end
              i2cm_pkg::PH_S2: begin
                scl_nxt = 1'b0;
                done    = 1'b1;
              end
              i2cm_pkg::PH_P1: begin
                scl_nxt   = 1'b1;
                phase_nxt = i2cm_pkg::PH_P2;
                tick_nxt  = seg_len;
              end
              i2cm_pkg::PH_P2: begin
                sda_nxt = 1'b1;
                done    = 1'b1;
              end
              i2cm_pkg::PH_WLOW: begin
                scl_nxt   = 1'b1;
                phase_nxt = i2cm_pkg::PH_WHIGH;
                tick_nxt  = seg_len;
              end
              i2cm_pkg::PH_WHIGH: begin
                bit_nxt = bit_inc;
                scl_nxt = 1'b0;
                if (bit_inc < 4'(i2cm_pkg::BITS_PER_BYTE)) begin
                  sda_nxt   = shift_r[3'd7 - bit_inc[2:0]];
                  phase_nxt = i2cm_pkg::PH_WLOW;
                  tick_nxt  = seg_len;
                end else begin
                  sda_nxt   = 1'b1;
                  phase_nxt = i2cm_pkg::PH_AWAIT;
                  wait_nxt  = (ack_wait_r == 8'd0) ? 8'd1 : ack_wait_r;
                end
              end
              i2cm_pkg::PH_AHIGH: begin
                status_nxt = sda_in ? i2cm_pkg::ST_LOST : i2cm_pkg::ST_ACKED;
                scl_nxt    = 1'b0;
                done       = 1'b1;
              end
              i2cm_pkg::PH_RLOW: begin
                scl_nxt   = 1'b1;
                phase_nxt = i2cm_pkg::PH_RHIGH;
                tick_nxt  = seg_len;
              end
              i2cm_pkg::PH_RHIGH: begin
                shift_nxt = {shift_r[6:0], sda_in};
                bit_nxt   = bit_inc;
                scl_nxt   = 1'b0;
                tick_nxt  = seg_len;
                if (bit_inc < 4'(i2cm_pkg::BITS_PER_BYTE)) begin
                  phase_nxt = i2cm_pkg::PH_RLOW;
                end else begin
                  sda_nxt   = !ack_wanted_r;
                  phase_nxt = i2cm_pkg::PH_KLOW;
                end
              end
              i2cm_pkg::PH_KLOW: begin
                scl_nxt   = 1'b1;
                phase_nxt = i2cm_pkg::PH_KHIGH;
                tick_nxt  = seg_len;
              end
              i2cm_pkg::PH_KHIGH: begin
                scl_nxt     = 1'b0;
                sda_nxt     = 1'b1;
                rx_hold_nxt = shift_r;
                done        = 1'b1;
              end
              default: begin
                phase_nxt = i2cm_pkg::PH_IDLE;
              end
            endcase
          end
        end
      endcase
      if (done) begin
        phase_nxt = i2cm_pkg::PH_IDLE;
        tick_nxt  = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= i2cm_pkg::PH_IDLE;
      bit_r        <= 4'd0;
      shift_r      <= 8'd0;
      tick_r       <= 8'd0;
      wait_r       <= 8'd0;
      ack_wanted_r <= 1'b0;
      status_r     <= 2'd0;
      rx_hold_r    <= 8'd0;
      scl_r        <= 1'b1;
      sda_r        <= 1'b1;
    end else begin
      phase_r      <= phase_nxt;
      bit_r        <= bit_nxt;
      shift_r      <= shift_nxt;
      tick_r       <= tick_nxt;
      wait_r       <= wait_nxt;
      ack_wanted_r <= ack_wanted_nxt;
      status_r     <= status_nxt;
      rx_hold_r    <= rx_hold_nxt;
      scl_r        <= scl_nxt;
      sda_r        <= sda_nxt;
    end
  end

  // result record shows the state after this tick
  assign res.scl_release = scl_nxt;
  assign res.sda_release = sda_nxt;
  assign res.busy_res    = (phase_nxt != i2cm_pkg::PH_IDLE);
  assign res.done_res    = done;
  assign res.rx_byte     = rx_hold_nxt;
  assign res.ack_status  = status_nxt;

  a_seg_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != i2cm_pkg::PH_IDLE && phase_r != i2cm_pkg::PH_AWAIT) |-> (tick_r != 8'd0))
    else $error("segment counter empty in a timed phase");

  a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (bit_r <= 4'(i2cm_pkg::BITS_PER_BYTE)))
    else $error("bit index past the byte");

  a_wait_live: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == i2cm_pkg::PH_AWAIT) |-> (wait_r != 8'd0))
    else $error("ACK wait counter empty while waiting");

endmodule

// File: rtl/i2cm_obuf.sv
// ----------------------------------------------------------------------------
// i2cm_obuf: result register with skid stage
// Two-entry output stage; keeps accepting while a single result waits downstream.
// ----------------------------------------------------------------------------
module i2cm_obuf (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  i2cm_pkg::res_t push_data,
  output logic           can_push,
  output logic           out_valid,
  input  logic           out_ready,
  output i2cm_pkg::res_t out_data
);

  i2cm_pkg::res_t out_r, out_nxt;
  i2cm_pkg::res_t skid_r, skid_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           skid_valid_r, skid_valid_nxt;
  logic           pop;

  assign can_push = !skid_valid_r;
  assign pop      = out_valid_r && out_ready;

  always_comb begin
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_nxt       = push_data;
        skid_valid_nxt = push;
      end else begin
        out_nxt       = push_data;
        out_valid_nxt = push;
      end
    end else if (push) begin
      skid_nxt       = push_data;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held with empty output register");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && out_ready) |=> (out_valid_r && !skid_valid_r))
    else $error("skid entry not moved forward on pop");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !out_ready) |=> $stable(skid_r))
    else $error("skid entry overwritten while full");

endmodule

// File: rtl/i2c_master_byte_engine_unit.sv
// ----------------------------------------------------------------------------
// i2c_master_byte_engine_unit: tick-stepped I2C master byte engine
// Start, stop, byte write and byte read on open-drain SCL/SDA, one timing
// tick per input transaction, one result transaction per input.
// ----------------------------------------------------------------------------
// Each input transaction is one tick of the bus sequencer and yields exactly
// one result transaction carrying the line levels and status after that tick.
// The block takes one transaction every clock: the sequencer state advances
// at the accepting edge and the result is loaded into a two-entry output
// stage (result register plus skid entry), into the skid entry only when
// the result register still holds an untaken result. in_ready drops only
// while both entries hold untaken results; throughput is then set by
// out_ready. While idle the sequencer starts the command in cmd (start,
// stop, write byte, read byte); commands arriving while busy are ignored.
// SCL half periods last half_bit_ticks ticks and the write ACK wait is
// bounded by ack_wait_limit ticks; a value of zero in either acts as one.
// Write the configuration registers only while no transaction is pending.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [2:0]                     in_cmd,
  input  logic [7:0]                     in_tx_byte,
  input  logic                           in_give_ack,
  input  logic                           in_sda_in,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_scl_release,
  output logic                           out_sda_release,
  output logic                           out_busy_res,
  output logic                           out_done_res,
  output logic [7:0]                     out_rx_byte,
  output logic [1:0]                     out_ack_status,
  // configuration port
  input  logic                           cfg_we,
  input  logic [i2cm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [i2cm_pkg::CFG_DAT_W-1:0] cfg_data
);

  logic           accept;
  i2cm_pkg::res_t step_res;
  i2cm_pkg::res_t out_res;

  // a transaction moves the sequencer only when the output stage has room
  assign accept = in_valid && in_ready;

  i2cm_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (accept),
    .cmd       (in_cmd),
    .tx_byte   (in_tx_byte),
    .give_ack  (in_give_ack),
    .sda_in    (in_sda_in),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res       (step_res)
  );

  // hold results here until the consumer takes them
  i2cm_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (step_res),
    .can_push  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_res)
  );

  assign out_scl_release = out_res.scl_release;
  assign out_sda_release = out_res.sda_release;
  assign out_busy_res    = out_res.busy_res;
  assign out_done_res    = out_res.done_res;
  assign out_rx_byte     = out_res.rx_byte;
  assign out_ack_status  = out_res.ack_status;

endmodule

// File: tb/sv/i2c_master_byte_engine_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2c_master_byte_engine_unit_test: self-checking bench for the byte engine
// Feeds tick transactions (commands, idle ticks, sampled SDA levels) through
// the valid/ready input, mirrors the bus sequencer in a local line-state
// predictor and compares every result transaction field by field. Runs two
// directed passes, then bus transfers with random content under several
// half-period and ACK-wait settings, most with random idling on both channels.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine_unit_test;

  localparam int RESET_CYCLES = 6;
  localparam int CYCLE_LIMIT = 400_000;
  localparam int DRAIN_CYCLES = 8;
  localparam int REPORT_CAP = 10;
  localparam int LONG_HOLD = 80;
  localparam int HOLD_EVERY = 500;
  localparam logic [2:0] CMD_CODE_MAX = 3'd7;
  // register indexes past the end of the map; writes there must be dropped
  localparam logic [i2cm_pkg::CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [i2cm_pkg::CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] tx_byte;
    logic       give_ack;
    logic       sda_in;
  } tick_item_t;

  // how the slave side drives SDA over one command's ticks
  typedef enum int {SDA_NOISE, SDA_HELD_HIGH, SDA_PULLED_LOW} sda_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                                 in_valid = 1'b0;
  logic                                 in_ready;
  logic [2:0]                           in_cmd = i2cm_pkg::CMD_TICK;
  logic [7:0]                           in_tx_byte = 8'h00;
  logic                                 in_give_ack = 1'b0;
  logic                                 in_sda_in = 1'b1;
  logic                                 out_valid;
  logic                                 out_ready = 1'b0;
  logic                                 out_scl_release;
  logic                                 out_sda_release;
  logic                                 out_busy_res;
  logic                                 out_done_res;
  logic [7:0]                           out_rx_byte;
  logic [1:0]                           out_ack_status;
  logic                                 cfg_we = 1'b0;
  logic [i2cm_pkg::CFG_IDX_W-1:0]       cfg_index = i2cm_pkg::CFG_HALF_BIT;
  logic [i2cm_pkg::CFG_DAT_W-1:0]       cfg_data = 8'h00;

  i2c_master_byte_engine_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_tx_byte      (in_tx_byte),
    .in_give_ack     (in_give_ack),
    .in_sda_in       (in_sda_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_scl_release (out_scl_release),
    .out_sda_release (out_sda_release),
    .out_busy_res    (out_busy_res),
    .out_done_res    (out_done_res),
    .out_rx_byte     (out_rx_byte),
    .out_ack_status  (out_ack_status),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Line-state predictor: a private copy of the sequencer and its registers,
  // starting from the reset values.
  // --------------------------------------------------------------------------
  logic [7:0]            half_q = i2cm_pkg::HALF_BIT_RST;
  logic [7:0]            wait_q = i2cm_pkg::ACK_WAIT_RST;
  i2cm_pkg::phase_t      seq_phase = i2cm_pkg::PH_IDLE;
  logic [3:0]            bit_idx = 4'd0;
  logic [7:0]            shreg = 8'h00;
  logic [7:0]            seg_cnt = 8'h00;
  logic [7:0]            ack_cnt = 8'h00;
  logic                  want_ack = 1'b0;
  i2cm_pkg::ack_status_t last_st = i2cm_pkg::ST_ACKED;
  logic [7:0]            rx_q = 8'h00;
  logic                  scl_q = 1'b1;
  logic                  sda_q = 1'b1;

  tick_item_t     tick_queue[$];
  i2cm_pkg::res_t pending_line_states[$];

  int queued_items = 0;
  int results_seen = 0;
  int fail_count = 0;
  int report_count = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int take_idle_pct = 0;

  // a zero half period or wait limit behaves as one
  function automatic logic [7:0] seg_ticks();
    return (half_q == 8'd0) ? 8'd1 : half_q;
  endfunction

  function automatic logic [7:0] ack_limit();
    return (wait_q == 8'd0) ? 8'd1 : wait_q;
  endfunction

  function automatic void enter_phase(i2cm_pkg::phase_t p);
    seq_phase = p;
    seg_cnt = seg_ticks();
  endfunction

  // Advance the sequencer by one tick and return the line state after it.
  function automatic i2cm_pkg::res_t advance_sequencer(logic [2:0] cmd, logic [7:0] tx,
                                                       logic gack, logic sda);
    i2cm_pkg::res_t r;
    logic fin;
    fin = 1'b0;
    if (seq_phase == i2cm_pkg::PH_IDLE) begin
      // unknown codes and commands while busy fall through as plain ticks
      if (cmd >= i2cm_pkg::CMD_START && cmd <= i2cm_pkg::CMD_READ) begin
        case (cmd)
          i2cm_pkg::CMD_START: begin
            scl_q = 1'b1;
            sda_q = 1'b1;
            enter_phase(i2cm_pkg::PH_S1);
          end
          i2cm_pkg::CMD_STOP: begin
            sda_q = 1'b0;
            enter_phase(i2cm_pkg::PH_P1);
          end
          i2cm_pkg::CMD_WRITE: begin
            shreg = tx;
            bit_idx = 4'd0;
            scl_q = 1'b0;
            sda_q = tx[i2cm_pkg::BITS_PER_BYTE-1];
            enter_phase(i2cm_pkg::PH_WLOW);
          end
          default: begin
            shreg = 8'h00;
            bit_idx = 4'd0;
            want_ack = gack;
            scl_q = 1'b0;
            sda_q = 1'b1;
            enter_phase(i2cm_pkg::PH_RLOW);
          end
        endcase
      end
    end else if (seq_phase == i2cm_pkg::PH_AWAIT) begin
      // slave pulls SDA low: clock the ACK bit, else burn the wait budget
      if (!sda) begin
        scl_q = 1'b1;
        enter_phase(i2cm_pkg::PH_AHIGH);
      end else begin
        ack_cnt = ack_cnt - 8'd1;
        if (ack_cnt == 8'd0) begin
          last_st = i2cm_pkg::ST_TIMEOUT;
          scl_q = 1'b0;
          fin = 1'b1;
        end
      end
    end else begin
      seg_cnt = seg_cnt - 8'd1;
      if (seg_cnt == 8'd0) begin
        case (seq_phase)
          i2cm_pkg::PH_S1: begin
            sda_q = 1'b0;
            enter_phase(i2cm_pkg::PH_S2);
          end
          i2cm_pkg::PH_S2: begin
            scl_q = 1'b0;
            fin = 1'b1;
          end
          i2cm_pkg::PH_P1: begin
            scl_q = 1'b1;
            enter_phase(i2cm_pkg::PH_P2);
          end
          i2cm_pkg::PH_P2: begin
            sda_q = 1'b1;
            fin = 1'b1;
          end
          i2cm_pkg::PH_WLOW: begin
            scl_q = 1'b1;
            enter_phase(i2cm_pkg::PH_WHIGH);
          end
          i2cm_pkg::PH_WHIGH: begin
            bit_idx = bit_idx + 4'd1;
            scl_q = 1'b0;
            if (bit_idx < 4'(i2cm_pkg::BITS_PER_BYTE)) begin
              sda_q = shreg[i2cm_pkg::BITS_PER_BYTE - 1 - bit_idx[2:0]];
              enter_phase(i2cm_pkg::PH_WLOW);
            end else begin
              sda_q = 1'b1;
              seq_phase = i2cm_pkg::PH_AWAIT;
              ack_cnt = ack_limit();
            end
          end
          i2cm_pkg::PH_AHIGH: begin
            last_st = sda ? i2cm_pkg::ST_LOST : i2cm_pkg::ST_ACKED;
            scl_q = 1'b0;
            fin = 1'b1;
          end
          i2cm_pkg::PH_RLOW: begin
            scl_q = 1'b1;
            enter_phase(i2cm_pkg::PH_RHIGH);
          end
          i2cm_pkg::PH_RHIGH: begin
            shreg = {shreg[6:0], sda};
            bit_idx = bit_idx + 4'd1;
            scl_q = 1'b0;
            if (bit_idx < 4'(i2cm_pkg::BITS_PER_BYTE)) begin
              enter_phase(i2cm_pkg::PH_RLOW);
            end else begin
              sda_q = !want_ack;
              enter_phase(i2cm_pkg::PH_KLOW);
            end
          end
          i2cm_pkg::PH_KLOW: begin
            scl_q = 1'b1;
            enter_phase(i2cm_pkg::PH_KHIGH);
          end
          i2cm_pkg::PH_KHIGH: begin
            scl_q = 1'b0;
            sda_q = 1'b1;
            rx_q = shreg;
            fin = 1'b1;
          end
          default: begin
            seq_phase = i2cm_pkg::PH_IDLE;
          end
        endcase
      end
    end
    if (fin) begin
      seq_phase = i2cm_pkg::PH_IDLE;
      seg_cnt = 8'd0;
    end
    r.scl_release = scl_q;
    r.sda_release = sda_q;
    r.busy_res = (seq_phase != i2cm_pkg::PH_IDLE);
    r.done_res = fin;
    r.rx_byte = rx_q;
    r.ack_status = last_st;
    return r;
  endfunction

  // Ticks a command needs at the current settings to run to completion.
  function automatic int cmd_ticks(logic [2:0] code);
    int seg;
    int lim;
    int nbits;
    seg = int'(seg_ticks());
    lim = int'(ack_limit());
    nbits = int'(i2cm_pkg::BITS_PER_BYTE);
    case (code)
      i2cm_pkg::CMD_START, i2cm_pkg::CMD_STOP: return 2 * seg;
      i2cm_pkg::CMD_WRITE: return (2 * nbits + 1) * seg + lim;
      i2cm_pkg::CMD_READ: return (2 * nbits + 2) * seg;
      default: return 0;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_item(logic [2:0] cmd, logic [7:0] tx, logic gack, logic sda);
    tick_queue.push_back('{cmd: cmd, tx_byte: tx, give_ack: gack, sda_in: sda});
    queued_items++;
  endtask

  task automatic push_run(int n, logic sda);
    repeat (n) push_item(i2cm_pkg::CMD_TICK, 8'($urandom_range(255)),
                         1'($urandom_range(1)), sda);
  endtask

  // Queue one command plus the ticks it should need. Now and then cut the
  // run short so the next command lands while the engine is still busy, and
  // sprinkle stray command codes among the ticks.
  task automatic queue_cmd(logic [2:0] code);
    int n;
    sda_mode_t mode;
    logic sda;
    logic [2:0] stray;
    n = cmd_ticks(code);
    if ($urandom_range(7) == 0) n = $urandom_range(n);
    mode = sda_mode_t'($urandom_range(2));
    push_item(code, 8'($urandom_range(255)), 1'($urandom_range(1)),
              1'($urandom_range(1)));
    repeat (n) begin
      case (mode)
        SDA_HELD_HIGH: sda = 1'b1;
        SDA_PULLED_LOW: sda = ($urandom_range(7) == 0);
        default: sda = 1'($urandom_range(1));
      endcase
      stray = ($urandom_range(7) == 0) ? 3'($urandom_range(CMD_CODE_MAX))
                                       : i2cm_pkg::CMD_TICK;
      push_item(stray, 8'($urandom_range(255)), 1'($urandom_range(1)), sda);
    end
  endtask

  // Hold until every queued transaction went in and every result came back.
  task automatic wait_bus_quiet();
    while (tick_queue.size() != 0 || in_valid || pending_line_states.size() != 0)
      @(negedge clk);
  endtask

  // Drain, then clock the sequencer idle so registers can be rewritten.
  task automatic settle_idle();
    wait_bus_quiet();
    while (seq_phase != i2cm_pkg::PH_IDLE) begin
      push_item(i2cm_pkg::CMD_TICK, 8'h00, 1'b0, 1'b1);
      wait_bus_quiet();
    end
  endtask

  task automatic write_reg(logic [i2cm_pkg::CFG_IDX_W-1:0] idx,
                           logic [i2cm_pkg::CFG_DAT_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == i2cm_pkg::CFG_HALF_BIT) half_q = val;
    else if (idx == i2cm_pkg::CFG_ACK_WAIT) wait_q = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly well-formed transfers (start, one to three bytes, stop) with
  // random content; the rest are lone random codes.
  task automatic run_traffic(int n_items);
    int target;
    target = queued_items + n_items;
    while (queued_items < target) begin
      if ($urandom_range(4) == 0) begin
        queue_cmd(3'($urandom_range(CMD_CODE_MAX)));
      end else begin
        queue_cmd(i2cm_pkg::CMD_START);
        repeat ($urandom_range(1, 3))
          queue_cmd($urandom_range(1) ? i2cm_pkg::CMD_WRITE : i2cm_pkg::CMD_READ);
        queue_cmd(i2cm_pkg::CMD_STOP);
      end
    end
    settle_idle();
  endtask

  task automatic check_line_state(i2cm_pkg::res_t got);
    i2cm_pkg::res_t want;
    int bad;
    if (pending_line_states.size() == 0) begin
      fail_count++;
      if (report_count < REPORT_CAP) begin
        report_count++;
        $display("result %0d unexpected: scl=%b sda=%b busy=%b done=%b rx=%02h ack=%0d",
                 results_seen, got.scl_release, got.sda_release, got.busy_res,
                 got.done_res, got.rx_byte, got.ack_status);
      end
      return;
    end
    want = pending_line_states.pop_front();
    bad = 0;
    if (got.scl_release !== want.scl_release) bad++;
    if (got.sda_release !== want.sda_release) bad++;
    if (got.busy_res !== want.busy_res) bad++;
    if (got.done_res !== want.done_res) bad++;
    if (got.rx_byte !== want.rx_byte) bad++;
    if (got.ack_status !== want.ack_status) bad++;
    if (bad != 0) begin
      fail_count++;
      if (report_count < REPORT_CAP) begin
        report_count++;
        $display("result %0d, %0d off: exp scl=%b sda=%b busy=%b done=%b rx=%02h ack=%0d",
                 results_seen, bad, want.scl_release, want.sda_release, want.busy_res,
                 want.done_res, want.rx_byte, want.ack_status);
        $display("  got scl=%b sda=%b busy=%b done=%b rx=%02h ack=%0d",
                 got.scl_release, got.sda_release, got.busy_res,
                 got.done_res, got.rx_byte, got.ack_status);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: on acceptance, predict the result of the transaction just taken;
  // then either present the next pending tick or idle. Valid stays up with a
  // steady payload until the engine takes it.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : feed
    tick_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid)
        pending_line_states.push_back(
          advance_sequencer(in_cmd, in_tx_byte, in_give_ack, in_sda_in));
      if (tick_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = tick_queue.pop_front();
        in_valid <= 1'b1;
        in_cmd <= nxt.cmd;
        in_tx_byte <= nxt.tx_byte;
        in_give_ack <= nxt.give_ack;
        in_sda_in <= nxt.sda_in;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check each accepted result, then pick the next ready level.
  // Every HOLD_EVERY results, stall for a long stretch so the output stage
  // fills and the engine pushes back on its input.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : take
    if (rst_n && out_valid && out_ready) begin
      check_line_state({out_scl_release, out_sda_release, out_busy_res,
                        out_done_res, out_rx_byte, out_ack_status});
      results_seen++;
      if (results_seen % HOLD_EVERY == HOLD_EVERY / 2) hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= take_idle_pct);
    end
  end

  // Watchdog: a stuck handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    send_idle_pct = 12;
    take_idle_pct = 68;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, reset settings: plain tick, unknown codes, start and stop.
    push_item(i2cm_pkg::CMD_TICK, 8'h00, 1'b0, 1'b1);
    for (int c = i2cm_pkg::CMD_READ + 1; c <= CMD_CODE_MAX; c++)
      push_item(3'(c), 8'hFF, 1'b1, 1'b0);
    push_item(i2cm_pkg::CMD_START, 8'h00, 1'b0, 1'b1);
    push_run(cmd_ticks(i2cm_pkg::CMD_START), 1'b1);
    push_item(i2cm_pkg::CMD_STOP, 8'hFF, 1'b1, 1'b1);
    push_run(cmd_ticks(i2cm_pkg::CMD_STOP), 1'b0);
    settle_idle();

    // Directed, one-tick half period and one-tick ACK wait.
    write_reg(i2cm_pkg::CFG_HALF_BIT, 8'd1);
    write_reg(i2cm_pkg::CFG_ACK_WAIT, 8'd1);
    push_item(i2cm_pkg::CMD_START, 8'h00, 1'b0, 1'b1);
    push_run(2, 1'b1);
    // all-ones byte, slave ACKs
    push_item(i2cm_pkg::CMD_WRITE, 8'hFF, 1'b0, 1'b1);
    push_run(16, 1'b1);
    push_run(2, 1'b0);
    // all-zeros byte, SDA stays high: ACK timeout; a read offered mid-byte
    // must be ignored
    push_item(i2cm_pkg::CMD_WRITE, 8'h00, 1'b1, 1'b0);
    push_item(i2cm_pkg::CMD_READ, 8'h00, 1'b1, 1'b1);
    push_run(16, 1'b1);
    // slave pulls SDA low but lets go before the sample: ACK lost
    push_item(i2cm_pkg::CMD_WRITE, 8'hA5, 1'b0, 1'b0);
    push_run(17, 1'b0);
    push_run(1, 1'b1);
    // read 0xFF and ACK it, then read 0x00 and NACK it
    push_item(i2cm_pkg::CMD_READ, 8'h00, 1'b1, 1'b0);
    push_run(18, 1'b1);
    push_item(i2cm_pkg::CMD_READ, 8'hFF, 1'b0, 1'b1);
    push_run(18, 1'b0);
    push_item(i2cm_pkg::CMD_STOP, 8'h00, 1'b0, 1'b0);
    push_run(2, 1'b1);
    settle_idle();

    run_traffic(150);

    // Swap idling; zero half period and zero wait limit act as one.
    send_idle_pct = 68;
    take_idle_pct = 12;
    write_reg(i2cm_pkg::CFG_HALF_BIT, 8'd0);
    write_reg(i2cm_pkg::CFG_ACK_WAIT, 8'd0);
    run_traffic(150);

    write_reg(i2cm_pkg::CFG_HALF_BIT, 8'd3);
    write_reg(i2cm_pkg::CFG_ACK_WAIT, 8'd40);
    run_traffic(200);

    // No idling; writes past the register map must not disturb the settings.
    send_idle_pct = 0;
    take_idle_pct = 0;
    write_reg(i2cm_pkg::CFG_HALF_BIT, 8'd5);
    write_reg(i2cm_pkg::CFG_ACK_WAIT, 8'd20);
    write_reg(CFG_SPARE_2, 8'($urandom_range(255)));
    write_reg(CFG_SPARE_3, 8'($urandom_range(255)));
    run_traffic(200);

    // Longest ACK wait at the shortest half period: one write transfer.
    write_reg(i2cm_pkg::CFG_HALF_BIT, 8'd1);
    write_reg(i2cm_pkg::CFG_ACK_WAIT, 8'd255);
    queue_cmd(i2cm_pkg::CMD_START);
    queue_cmd(i2cm_pkg::CMD_WRITE);
    queue_cmd(i2cm_pkg::CMD_STOP);
    settle_idle();

    // let any stray result show up before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: i2c_master_byte_engine_unit.f
rtl/i2cm_pkg.sv
rtl/i2cm_core.sv
rtl/i2cm_obuf.sv
rtl/i2c_master_byte_engine_unit.sv
tb/sv/i2c_master_byte_engine_unit_test.sv
